/* rtl/tbs_pkg.sv */
`default_nettype none

package tbs_pkg;

    // Band geometry: a block is four words wide and eight rows tall.
    localparam int BAND_ROWS     = 8;
    localparam int ROW_W         = 3;
    localparam int BLOCK_WORDS   = 4;
    localparam int WORD_W        = 2;
    localparam int EMIT_W        = 5;
    localparam int MAX_BANDS     = 64;
    localparam int BAND_W        = 6;

    localparam int PIXEL_W       = 32;
    localparam int WB_W          = 8;
    localparam int HB_W          = 7;

    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_BLOCKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_BANDS = 1'b1;

    localparam logic [WB_W-1:0] WIDTH_BLOCKS_RST = 8'd128;
    localparam logic [HB_W-1:0] HEIGHT_BANDS_RST = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } ctrl_state_t;

    typedef struct packed {
        logic block_last;
        logic image_last;
    } out_flags_t;

endpackage

`default_nettype wire

/* rtl/texture_block_swizzler.sv */
`default_nettype none

// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_pixel_in  (raster order pixel)
// m_        out        m_valid / m_ready   m_pixel_out, m_block_last, m_image_last
// cfg_      in         cfg_we (no wait)    cfg_index, cfg_wdata
//
// One pixel per cycle is taken into the band store while no block is draining.
// The pixel that closes a block (fourth word of a group in row 7) starts a
// drain of its 32 words through the single read port; input is held off
// until the last read issues.
// aresetn is synchronous, active low; the band store has no reset or clear pass.
// A stalled m_ready freezes the read port: the memory read register is the output.

module texture_block_swizzler
    import tbs_pkg::*;
#(
    parameter int MAX_ROW_WORDS = 512
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [PIXEL_W-1:0]    s_pixel_in,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [PIXEL_W-1:0]         m_pixel_out,
    output logic                       m_block_last,
    output logic                       m_image_last
);

    // column splits into block index and word in block; store is {row, block, word}
    localparam int COL_W  = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
    localparam int BLK_W  = (COL_W > WORD_W) ? COL_W - WORD_W : 1;
    localparam int ADDR_W = ROW_W + BLK_W + WORD_W;

    logic [WB_W-1:0]   width_blocks_reg, width_blocks_next;
    logic [HB_W-1:0]   height_bands_reg, height_bands_next;
    logic              cfg_clear;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    out_flags_t        m_flags;

    // Config writes; every known index also restarts the image counters.
    always_comb begin
        width_blocks_next = width_blocks_reg;
        height_bands_next = height_bands_reg;
        cfg_clear         = 1'b0;
        if (cfg_we) begin
            case (cfg_index)
                CFG_WIDTH_BLOCKS: begin
                    width_blocks_next = cfg_wdata[WB_W-1:0];
                    cfg_clear         = 1'b1;
                end
                CFG_HEIGHT_BANDS: begin
                    height_bands_next = cfg_wdata[HB_W-1:0];
                    cfg_clear         = 1'b1;
                end
                default: begin
                    cfg_clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_blocks_reg <= WIDTH_BLOCKS_RST;
            height_bands_reg <= HEIGHT_BANDS_RST;
        end else begin
            width_blocks_reg <= width_blocks_next;
            height_bands_reg <= height_bands_next;
        end
    end

    tbs_ctrl #(
        .MAX_ROW_WORDS (MAX_ROW_WORDS),
        .BLK_W         (BLK_W),
        .ADDR_W        (ADDR_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .width_blocks (width_blocks_reg),
        .height_bands (height_bands_reg),
        .cfg_clear    (cfg_clear),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_flags      (m_flags)
    );

    // band store: written on each input transfer, read during block drain
    tbs_band_mem #(
        .ADDR_W (ADDR_W)
    ) u_band_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (s_pixel_in),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (m_pixel_out)
    );

    assign m_block_last = m_flags.block_last;
    assign m_image_last = m_flags.image_last;

`ifndef NO_ASSERTIONS
    // writes and drain reads never share a cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("band store written and read in one cycle");

    // image end only ever closes a block
    a_image_in_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_image_last) |-> m_block_last)
        else $error("image_last without block_last");

    // an issued read always lands in the output register
    a_read_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_re |=> m_valid)
        else $error("drain read lost");
`endif

endmodule

`default_nettype wire

/* rtl/tbs_band_mem.sv */
`default_nettype none

module tbs_band_mem
    import tbs_pkg::*;
#(
    parameter int ADDR_W = 12
) (
    input  wire logic               aclk,
    input  wire logic               we,
    input  wire logic [ADDR_W-1:0]  waddr,
    input  wire logic [PIXEL_W-1:0] wdata,
    input  wire logic               re,
    input  wire logic [ADDR_W-1:0]  raddr,
    output logic      [PIXEL_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data register doubles as the output register; it holds while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/tbs_ctrl.sv */
`default_nettype none

module tbs_ctrl
    import tbs_pkg::*;
#(
    parameter int MAX_ROW_WORDS = 512,
    parameter int BLK_W         = 7,
    parameter int ADDR_W        = 12
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [WB_W-1:0]   width_blocks,
    input  wire logic [HB_W-1:0]   height_bands,
    input  wire logic              cfg_clear,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   mem_we,
    output logic [ADDR_W-1:0]      mem_waddr,
    output logic                   mem_re,
    output logic [ADDR_W-1:0]      mem_raddr,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_flags_t             m_flags
);

    localparam int WB_MAX = MAX_ROW_WORDS / BLOCK_WORDS;

    ctrl_state_t        state_reg, state_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [BLK_W-1:0]   blk_reg, blk_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [BAND_W-1:0]  band_reg, band_next;
    logic [BLK_W-1:0]   emit_blk_reg, emit_blk_next;
    logic               img_end_reg, img_end_next;
    logic [EMIT_W-1:0]  ecnt_reg, ecnt_next;
    logic               m_valid_reg, m_valid_next;
    out_flags_t         flags_reg, flags_next;

    logic [WB_W-1:0]    wb_dec;
    logic [BLK_W-1:0]   blk_max;
    logic [BAND_W-1:0]  band_max;
    logic               s_fire;
    logic               blk_done;
    logic               emit_last;

    // last block index of a row, zero width taken as one, saturated to the store
    always_comb begin
        wb_dec = (width_blocks == '0) ? '0 : width_blocks - WB_W'(1);
        if (32'(wb_dec) > 32'(WB_MAX - 1)) begin
            blk_max = BLK_W'(WB_MAX - 1);
        end else begin
            blk_max = BLK_W'(wb_dec);
        end
    end

    always_comb begin
        if (height_bands == '0) begin
            band_max = '0;
        end else if (height_bands > HB_W'(MAX_BANDS)) begin
            band_max = BAND_W'(MAX_BANDS - 1);
        end else begin
            band_max = BAND_W'(height_bands - HB_W'(1));
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign blk_done  = (row_reg == ROW_W'(BAND_ROWS - 1)) && (word_reg == WORD_W'(BLOCK_WORDS - 1));
    assign mem_we    = s_fire;
    assign mem_waddr = {row_reg, blk_reg, word_reg};

    assign mem_re    = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign mem_raddr = {ecnt_reg[EMIT_W-1:WORD_W], emit_blk_reg, ecnt_reg[WORD_W-1:0]};
    assign emit_last = (ecnt_reg == '1);

    always_comb begin
        state_next    = state_reg;
        word_next     = word_reg;
        blk_next      = blk_reg;
        row_next      = row_reg;
        band_next     = band_reg;
        emit_blk_next = emit_blk_reg;
        img_end_next  = img_end_reg;
        ecnt_next     = ecnt_reg;
        flags_next    = flags_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    word_next = word_reg + WORD_W'(1);
                    if (word_reg == WORD_W'(BLOCK_WORDS - 1)) begin
                        if (blk_reg == blk_max) begin
                            blk_next = '0;
                            row_next = row_reg + ROW_W'(1);
                            if (row_reg == ROW_W'(BAND_ROWS - 1)) begin
                                band_next = (band_reg == band_max) ? '0 : band_reg + BAND_W'(1);
                            end
                        end else begin
                            blk_next = blk_reg + BLK_W'(1);
                        end
                    end
                    if (blk_done) begin
                        state_next    = ST_EMIT;
                        emit_blk_next = blk_reg;
                        img_end_next  = (blk_reg == blk_max) && (band_reg == band_max);
                        ecnt_next     = '0;
                    end
                end
            end
            ST_EMIT: begin
                if (mem_re) begin
                    m_valid_next          = 1'b1;
                    flags_next.block_last = emit_last;
                    flags_next.image_last = emit_last && img_end_reg;
                    ecnt_next             = ecnt_reg + EMIT_W'(1);
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_clear) begin
            word_next = '0;
            blk_next  = '0;
            row_next  = '0;
            band_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            word_reg    <= '0;
            blk_reg     <= '0;
            row_reg     <= '0;
            band_reg    <= '0;
            ecnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            word_reg    <= word_next;
            blk_reg     <= blk_next;
            row_reg     <= row_next;
            band_reg    <= band_next;
            ecnt_reg    <= ecnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        emit_blk_reg <= emit_blk_next;
        img_end_reg  <= img_end_next;
        flags_reg    <= flags_next;
    end

    assign m_valid = m_valid_reg;
    assign m_flags = flags_reg;

endmodule

`default_nettype wire
